### rtl/bsmd_pkg.sv
`timescale 1ns / 1ps
// bsmd_pkg: shared types and constants of the bus shadow memory decoder
// no dependencies; used by every module of the block

package bsmd_pkg;

	localparam int DEF_MAIN_BYTES  = 8192;
	localparam int DEF_UPPER_BYTES = 4096;

	localparam logic [15:0] MAIN_BASE   = 16'h8000;
	localparam logic [15:0] UPPER_BASE  = 16'hA000;
	localparam logic [15:0] UPPER_END   = 16'hB000;
	localparam logic [15:0] FONT_ADDR   = 16'hE84C;
	localparam logic [15:0] COLUMN_ADDR = 16'hE000;
	localparam int          FONT_BIT    = 1;

	// offset within a window, wide enough for the largest store
	localparam int OFS_W = 13;

	localparam int QUEUE_DEPTH = 2;
	localparam int QAW         = $clog2(QUEUE_DEPTH);
	localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		OP_NONE,
		OP_RD_MAIN,
		OP_WR_MAIN,
		OP_RD_UPPER,
		OP_WR_UPPER,
		OP_FONT,
		OP_COLUMN
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [OFS_W-1:0] offset;
		logic [7:0]       data;
	} q_entry_t;

endpackage

### rtl/bsmd_front.sv
`timescale 1ns / 1ps
// bsmd_front: accepts bus requests, decodes the address window and queues an operation
// depends on bsmd_pkg; holds the upper window enable register

module bsmd_front #(
	parameter int MAIN_BYTES  = bsmd_pkg::DEF_MAIN_BYTES,
	parameter int UPPER_BYTES = bsmd_pkg::DEF_UPPER_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write_enable,
	input  logic                cfg_write_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [15:0]         bus_address,
	input  logic [7:0]          bus_data,
	input  logic                clear_busy,
	input  logic                q_ready,
	output logic                q_push,
	output bsmd_pkg::q_entry_t  q_entry
);
	import bsmd_pkg::*;

	localparam int MAIN_STEPS  = (8192 + MAIN_BYTES - 1) / MAIN_BYTES - 1;
	localparam int UPPER_STEPS = (4096 + UPPER_BYTES - 1) / UPPER_BYTES - 1;
	localparam logic [OFS_W:0] MAIN_LIM  = (OFS_W + 1)'(MAIN_BYTES);
	localparam logic [OFS_W:0] UPPER_LIM = (OFS_W + 1)'(UPPER_BYTES);

	logic             upper_window_enable_q;
	logic             in_main;
	logic             in_upper;
	logic [OFS_W:0]   main_ofs;
	logic [OFS_W:0]   upper_ofs;
	op_t              op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_window_enable_q <= 1'b1;
		end else if (cfg_write_enable) begin
			upper_window_enable_q <= cfg_write_data;
		end
	end

	assign in_main  = (bus_address >= MAIN_BASE) && (bus_address < UPPER_BASE);
	assign in_upper = upper_window_enable_q && (bus_address >= UPPER_BASE) &&
		(bus_address < UPPER_END);

	// offset wraps modulo the store size
	always_comb begin
		main_ofs = {1'b0, bus_address[OFS_W-1:0]};
		for (int i = 0; i < MAIN_STEPS; i++) begin
			if (main_ofs >= MAIN_LIM) main_ofs = main_ofs - MAIN_LIM;
		end
		upper_ofs = {2'b00, bus_address[11:0]};
		for (int i = 0; i < UPPER_STEPS; i++) begin
			if (upper_ofs >= UPPER_LIM) upper_ofs = upper_ofs - UPPER_LIM;
		end
	end

	always_comb begin
		op = OP_NONE;
		if (cmd) begin
			if (in_main) op = OP_WR_MAIN;
			else if (in_upper) op = OP_WR_UPPER;
			else if (bus_address == FONT_ADDR) op = OP_FONT;
			else if (bus_address == COLUMN_ADDR) op = OP_COLUMN;
		end else begin
			if (in_main) op = OP_RD_MAIN;
			else if (in_upper) op = OP_RD_UPPER;
		end
	end

	assign in_ready       = q_ready && !clear_busy;
	assign q_push         = in_valid && in_ready;
	assign q_entry.op     = op;
	assign q_entry.offset = in_main ? main_ofs[OFS_W-1:0] : upper_ofs[OFS_W-1:0];
	assign q_entry.data   = bus_data;

endmodule

### rtl/bsmd_queue.sv
`timescale 1ns / 1ps
// bsmd_queue: short queue of decoded operations between front and back
// depends on bsmd_pkg

module bsmd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bsmd_pkg::q_entry_t  push_entry,
	output logic                push_ready,
	input  logic                pop,
	output logic                pop_valid,
	output bsmd_pkg::q_entry_t  pop_entry
);
	import bsmd_pkg::*;

	q_entry_t         slot_q [QUEUE_DEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != QCW'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_entry  = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/bsmd_back.sv
`timescale 1ns / 1ps
// bsmd_back: carries out queued operations on the two stores and the flags
// depends on bsmd_pkg; holds both stores, the clearing pass and the result register

module bsmd_back #(
	parameter int MAIN_BYTES  = bsmd_pkg::DEF_MAIN_BYTES,
	parameter int UPPER_BYTES = bsmd_pkg::DEF_UPPER_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  bsmd_pkg::q_entry_t  q_entry,
	output logic                q_pop,
	output logic                clear_busy,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                drive_enable,
	output logic [7:0]          read_byte,
	output logic                lowercase_font,
	output logic                eighty_column
);
	import bsmd_pkg::*;

	localparam int MAIN_AW  = $clog2(MAIN_BYTES);
	localparam int UPPER_AW = $clog2(UPPER_BYTES);
	localparam logic [MAIN_AW:0] UPPER_LIM = (MAIN_AW + 1)'(UPPER_BYTES);

	logic [7:0]          main_mem  [MAIN_BYTES];
	logic [7:0]          upper_mem [UPPER_BYTES];

	logic                clearing_q;
	logic [MAIN_AW-1:0]  clr_q;
	logic                font_q;
	logic                column_q;
	logic [7:0]          main_rd_q;
	logic [7:0]          upper_rd_q;

	logic                valid_s1;
	op_t                 op_s1;
	logic                out_valid_s2;
	logic                drive_s2;
	logic [7:0]          byte_s2;
	logic                font_s2;
	logic                column_s2;

	logic                advance;
	logic                main_we;
	logic                main_re;
	logic [MAIN_AW-1:0]  main_addr;
	logic                upper_we;
	logic                upper_re;
	logic [UPPER_AW-1:0] upper_addr;
	logic [7:0]          wdata;

	assign advance    = !out_valid_s2 || out_ready;
	assign q_pop      = q_valid && !clearing_q && (!valid_s1 || advance);
	assign clear_busy = clearing_q;

	assign main_we   = clearing_q || (q_pop && q_entry.op == OP_WR_MAIN);
	assign main_re   = q_pop && q_entry.op == OP_RD_MAIN;
	assign main_addr = clearing_q ? clr_q : q_entry.offset[MAIN_AW-1:0];
	assign upper_we  = (clearing_q && ({1'b0, clr_q} < UPPER_LIM)) ||
		(q_pop && q_entry.op == OP_WR_UPPER);
	assign upper_re   = q_pop && q_entry.op == OP_RD_UPPER;
	assign upper_addr = clearing_q ? clr_q[UPPER_AW-1:0] : q_entry.offset[UPPER_AW-1:0];
	assign wdata      = clearing_q ? 8'h00 : q_entry.data;

	always_ff @(posedge clk) begin
		if (main_we) main_mem[main_addr] <= wdata;
		if (main_re) main_rd_q <= main_mem[main_addr];
	end

	always_ff @(posedge clk) begin
		if (upper_we) upper_mem[upper_addr] <= wdata;
		if (upper_re) upper_rd_q <= upper_mem[upper_addr];
	end

	// clearing pass over both stores after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			if (clr_q == MAIN_AW'(MAIN_BYTES - 1)) clearing_q <= 1'b0;
			else clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_q   <= 1'b0;
			column_q <= 1'b1;
		end else if (q_pop) begin
			case (q_entry.op)
				OP_FONT:   font_q   <= q_entry.data[FONT_BIT];
				OP_COLUMN: column_q <= (q_entry.data == 8'h00);
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (q_pop) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) op_s1 <= q_entry.op;
		if (advance && valid_s1) begin
			font_s2   <= font_q;
			column_s2 <= column_q;
			case (op_s1)
				OP_RD_MAIN: begin
					drive_s2 <= 1'b1;
					byte_s2  <= main_rd_q;
				end
				OP_RD_UPPER: begin
					drive_s2 <= 1'b1;
					byte_s2  <= upper_rd_q;
				end
				default: begin
					drive_s2 <= 1'b0;
					byte_s2  <= 8'h00;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_s2;
	assign drive_enable   = drive_s2;
	assign read_byte      = byte_s2;
	assign lowercase_font = font_s2;
	assign eighty_column  = column_s2;

	a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !q_pop)
		else $error("request taken during clearing pass");

	a_stalled_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(op_s1))
		else $error("stalled operation lost");

	a_clear_full_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |-> $past(clr_q) == MAIN_AW'(MAIN_BYTES - 1))
		else $error("clearing pass ended early");

endmodule

### rtl/bus_shadow_memory_decoder_top.sv
`timescale 1ns / 1ps
// bus_shadow_memory_decoder_top: top level of the bus shadow memory decoder
// depends on bsmd_pkg, bsmd_front, bsmd_queue, bsmd_back

// Snooping shadow slave for an 8-bit bus. One request is accepted per clock and one
// result comes out per clock, sustained while out_ready is high and no clearing pass
// runs; a taken request passes through the queue pop, the store access with registered
// read and the result register. The front decodes the window and the back executes,
// with a two-entry queue between them so either side may stall. After reset a clearing
// pass zeroes both stores, one word per clock over every main store address; in_ready
// stays low until it ends, while configuration writes are taken as ever.

module bus_shadow_memory_decoder_top #(
	parameter int MAIN_BYTES  = bsmd_pkg::DEF_MAIN_BYTES,
	parameter int UPPER_BYTES = bsmd_pkg::DEF_UPPER_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_enable,
	input  logic        cfg_write_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [15:0] bus_address,
	input  logic [7:0]  bus_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        drive_enable,
	output logic [7:0]  read_byte,
	output logic        lowercase_font,
	output logic        eighty_column
);
	import bsmd_pkg::*;

	logic      clear_busy;
	logic      push;
	logic      push_ready;
	q_entry_t  push_entry;
	logic      pop;
	logic      pop_valid;
	q_entry_t  pop_entry;

	bsmd_front #(
		.MAIN_BYTES  (MAIN_BYTES),
		.UPPER_BYTES (UPPER_BYTES)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_write_data   (cfg_write_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.cmd              (cmd),
		.bus_address      (bus_address),
		.bus_data         (bus_data),
		.clear_busy       (clear_busy),
		.q_ready          (push_ready),
		.q_push           (push),
		.q_entry          (push_entry)
	);

	bsmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry)
	);

	bsmd_back #(
		.MAIN_BYTES  (MAIN_BYTES),
		.UPPER_BYTES (UPPER_BYTES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (pop_valid),
		.q_entry        (pop_entry),
		.q_pop          (pop),
		.clear_busy     (clear_busy),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.drive_enable   (drive_enable),
		.read_byte      (read_byte),
		.lowercase_font (lowercase_font),
		.eighty_column  (eighty_column)
	);

endmodule
